@@ rtl/lip_pkg.sv @@
// Shared types and constants for the 1D Lagrange interpolator.
`default_nettype none
package lip_pkg;

   localparam int SAMPLE_W = 24;
   localparam int POS_W    = 19;
   localparam int NODE_W   = 4;
   localparam int WEIGHT_W = 32;
   localparam int BMAG_W   = 31;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // round(2^30 / d) for node distance d, half rounded up; entry 0 unused
   localparam logic [BMAG_W-1:0] RECIP [0:15] = '{
      31'd0,
      31'd1073741824,
      31'd536870912,
      31'd357913941,
      31'd268435456,
      31'd214748365,
      31'd178956971,
      31'd153391689,
      31'd134217728,
      31'd119304647,
      31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0
   };

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [POS_W-1:0]           pos;
      logic [NODE_W-1:0]          node;
      logic                       used;
      logic                       last;
   } lip_entry_type;

endpackage
`default_nettype wire

@@ rtl/lip_front.sv @@
// Front end: accepts samples, tracks node index and query position.
`default_nettype none
module lip_front import lip_pkg::*; #(
   parameter int NGHOST = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic [POS_W-1:0]           req_position,
   input  wire logic                       req_last,
   input  wire logic                       q_full,
   output      logic                       busy,
   output      logic                       push,
   output      lip_entry_type              push_entry
);

   localparam int NNODES = 2 * NGHOST + 2;

   logic [NODE_W-1:0] node_ff, node_in;
   logic [POS_W-1:0]  qpos_ff, qpos_in;
   logic              first;
   logic              used;

   assign busy  = q_full;
   assign push  = start && !q_full;
   assign first = (node_ff == '0);
   assign used  = (node_ff < NODE_W'(NNODES));

   always_comb begin
      qpos_in = qpos_ff;
      node_in = node_ff;
      if (push) begin
         if (first) begin
            qpos_in = req_position;
         end
         if (req_last) begin
            node_in = '0;
         end else if (used) begin
            node_in = node_ff + NODE_W'(1);
         end
      end
   end

   always_comb begin
      push_entry.sample = req_sample;
      push_entry.pos    = first ? req_position : qpos_ff;
      push_entry.node   = node_ff;
      push_entry.used   = used;
      push_entry.last   = req_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= '0;
         qpos_ff <= '0;
      end else begin
         node_ff <= node_in;
         qpos_ff <= qpos_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lip_queue.sv @@
// Two-entry queue between front end and back end.
`default_nettype none
module lip_queue import lip_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire lip_entry_type push_entry,
   input  wire logic          pop,
   output      logic          full,
   output      logic          not_empty,
   output      lip_entry_type head
);

   lip_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lip_back.sv @@
// Back end: node weight on a shared multiplier, accumulate, round and emit.
`default_nettype none
module lip_back import lip_pkg::*; #(
   parameter int NGHOST = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_valid,
   input  wire lip_entry_type              q_entry,
   output      logic                       q_pop,
   output      logic                       rsp_valid,
   output      logic signed [SAMPLE_W-1:0] rsp_value,
   output      logic                       rsp_overflow
);

   localparam int NNODES = 2 * NGHOST + 2;
   localparam int FULL_W = 95;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_NEXT  = 4'd1;
   localparam logic [3:0] S_MULA  = 4'd2;
   localparam logic [3:0] S_MULB  = 4'd3;
   localparam logic [3:0] S_MULC  = 4'd4;
   localparam logic [3:0] S_WSAT  = 4'd5;
   localparam logic [3:0] S_SMUL  = 4'd6;
   localparam logic [3:0] S_ACC   = 4'd7;
   localparam logic [3:0] S_ROUND = 4'd8;

   localparam logic [62:0]       W_ONE     = 63'h0000_0000_4000_0000;
   localparam logic [FULL_W-1:0] MAG_LIMIT = FULL_W'(1) << 62;
   localparam logic [FULL_W-1:0] RND16     = FULL_W'(1) << 15;
   localparam logic [FULL_W-1:0] RND30     = FULL_W'(1) << 29;
   localparam logic [62:0]       WPOS_MAX  = 63'h0000_0000_7FFF_FFFF;
   localparam logic [62:0]       WNEG_MAX  = 63'h0000_0000_8000_0000;
   localparam logic [34:0]       OPOS_MAX  = 35'd8388607;
   localparam logic [34:0]       ONEG_MAX  = 35'd8388608;

   logic [3:0]                 state_ff, state_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [NODE_W-1:0]          node_ff, node_in;
   logic                       last_ff, last_in;
   logic [NODE_W-1:0]          j_ff, j_in;
   logic                       phase_ff, phase_in;
   logic [62:0]                wmag_ff, wmag_in;
   logic                       wneg_ff, wneg_in;
   logic [62:0]                plo_ff, plo_in;
   logic [61:0]                phi_ff, phi_in;
   logic signed [WEIGHT_W-1:0] wq_ff, wq_in;
   logic signed [55:0]         prod_ff, prod_in;
   logic [63:0]                acc_ff, acc_in;
   logic                       vld_ff, vld_in;
   logic signed [SAMPLE_W-1:0] val_ff, val_in;
   logic                       ovf_ff, ovf_in;

   // multiplier operand: (t - j) in Q16 or reciprocal of (i - j) in Q30
   logic signed [23:0] diff;
   logic [23:0]        dmag;
   logic [4:0]         dnode;
   logic [4:0]         anode;
   logic [BMAG_W-1:0]  bmag;
   logic               bneg;
   logic [31:0]        mul_a;
   logic [62:0]        mul_p;
   logic [FULL_W-1:0]  full;
   logic [FULL_W-1:0]  shifted;
   logic [64:0]        rsum;
   logic [34:0]        rq;
   logic               aneg;

   always_comb begin
      diff  = $signed({5'b0, pos_ff}) - $signed({4'b0, j_ff, 16'b0});
      dmag  = diff[23] ? -diff : diff;
      dnode = {1'b0, node_ff} - {1'b0, j_ff};
      anode = dnode[4] ? -dnode : dnode;
      if (phase_ff) begin
         bmag = RECIP[anode[3:0]];
         bneg = dnode[4];
      end else begin
         bmag = {7'b0, dmag};
         bneg = diff[23];
      end
   end

   // One multiplier: low word of the weight first, then the high word
   assign mul_a = (state_ff == S_MULB) ? {1'b0, wmag_ff[62:32]} : wmag_ff[31:0];
   assign mul_p = mul_a * bmag;

   always_comb begin
      full    = {1'b0, phi_ff, 32'b0} + {32'b0, plo_ff} + (phase_ff ? RND30 : RND16);
      shifted = phase_ff ? (full >> 30) : (full >> 16);
   end

   always_comb begin
      aneg = acc_ff[63];
      rsum = aneg ? ({1'b0, ~acc_ff} + 65'h0_0000_0000_2000_0001)
                  : ({1'b0, acc_ff} + 65'h0_0000_0000_2000_0000);
      rq   = rsum[64:30];
   end

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      pos_in    = pos_ff;
      node_in   = node_ff;
      last_in   = last_ff;
      j_in      = j_ff;
      phase_in  = phase_ff;
      wmag_in   = wmag_ff;
      wneg_in   = wneg_ff;
      plo_in    = plo_ff;
      phi_in    = phi_ff;
      wq_in     = wq_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      vld_in    = 1'b0;
      val_in    = val_ff;
      ovf_in    = ovf_ff;
      q_pop     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               sample_in = q_entry.sample;
               pos_in    = q_entry.pos;
               node_in   = q_entry.node;
               last_in   = q_entry.last;
               j_in      = '0;
               phase_in  = 1'b0;
               wmag_in   = W_ONE;
               wneg_in   = 1'b0;
               if (q_entry.used) begin
                  state_in = S_NEXT;
               end else if (q_entry.last) begin
                  state_in = S_ROUND;
               end
            end
         end
         S_NEXT: begin
            if (j_ff == NODE_W'(NNODES)) begin
               state_in = S_WSAT;
            end else if (j_ff == node_ff) begin
               j_in = j_ff + NODE_W'(1);
            end else begin
               state_in = S_MULA;
            end
         end
         S_MULA: begin
            plo_in   = mul_p;
            state_in = S_MULB;
         end
         S_MULB: begin
            phi_in   = mul_p[61:0];
            state_in = S_MULC;
         end
         S_MULC: begin
            wmag_in = (shifted > MAG_LIMIT) ? MAG_LIMIT[62:0] : shifted[62:0];
            wneg_in = wneg_ff ^ bneg;
            if (phase_ff) begin
               phase_in = 1'b0;
               j_in     = j_ff + NODE_W'(1);
               state_in = S_NEXT;
            end else begin
               phase_in = 1'b1;
               state_in = S_MULA;
            end
         end
         S_WSAT: begin
            if (!wneg_ff) begin
               wq_in = (wmag_ff > WPOS_MAX) ? WPOS_MAX[31:0] : wmag_ff[31:0];
            end else begin
               wq_in = (wmag_ff > WNEG_MAX) ? WNEG_MAX[31:0] : -wmag_ff[31:0];
            end
            state_in = S_SMUL;
         end
         S_SMUL: begin
            prod_in  = sample_ff * wq_ff;
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in   = acc_ff + {{8{prod_ff[55]}}, prod_ff};
            state_in = last_ff ? S_ROUND : S_IDLE;
         end
         S_ROUND: begin
            vld_in = 1'b1;
            if (!aneg && rq > OPOS_MAX) begin
               val_in = OPOS_MAX[23:0];
               ovf_in = 1'b1;
            end else if (aneg && rq > ONEG_MAX) begin
               val_in = ONEG_MAX[23:0];
               ovf_in = 1'b1;
            end else begin
               val_in = aneg ? -rq[23:0] : rq[23:0];
               ovf_in = 1'b0;
            end
            acc_in   = '0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      pos_ff    <= pos_in;
      node_ff   <= node_in;
      last_ff   <= last_in;
      j_ff      <= j_in;
      phase_ff  <= phase_in;
      wmag_ff   <= wmag_in;
      wneg_ff   <= wneg_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      wq_ff     <= wq_in;
      prod_ff   <= prod_in;
      val_ff    <= val_in;
      ovf_ff    <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         acc_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_valid    = vld_ff;
   assign rsp_value    = val_ff;
   assign rsp_overflow = ovf_ff;

endmodule
`default_nettype wire

@@ rtl/lagrange_interp_1d.sv @@
// Result: rsp_valid rises once the last sample has run its weight loop over the
//   NNODES = 2*NGHOST+2 nodes and then S_WSAT, S_SMUL, S_ACC and S_ROUND.
// Flow: the back end works on one queued sample at a time; each weight factor
//   takes two passes on the one shared 32x31 multiplier, each with a rounding.
// Reset: synchronous, clears node index, query position, accumulator and queue.
// The result strobe lasts one cycle; the receiver has no way to stall it.
`default_nettype none
module lagrange_interp_1d import lip_pkg::*; #(
   parameter int NGHOST = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output      logic                       busy,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic [POS_W-1:0]           req_position,
   input  wire logic                       req_last,
   output      logic                       rsp_valid,
   output      logic signed [SAMPLE_W-1:0] rsp_value,
   output      logic                       rsp_overflow
);

   // Front end to queue: one entry per transferred sample, already tagged
   // with its node index, the position of its set and whether it counts.
   lip_entry_type push_entry;
   lip_entry_type head;
   logic          push;
   logic          q_full;
   logic          q_valid;
   logic          q_pop;

   // Classify each sample; hold off start only while the queue is full.
   lip_front #(
      .NGHOST (NGHOST)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_sample   (req_sample),
      .req_position (req_position),
      .req_last     (req_last),
      .q_full       (q_full),
      .busy         (busy),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Decouple the fast front end from the long weight computation.
   lip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_valid),
      .head       (head)
   );

   // Build the node weight, multiply-accumulate, round and emit on last.
   lip_back #(
      .NGHOST (NGHOST)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_overflow)
   );

endmodule
`default_nettype wire

@@ rtl/lip_checker.sv @@
// Port-level assertions for the interpolator, bound to the top level.
`default_nettype none
module lip_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [23:0] rsp_value,
   input wire logic        rsp_overflow
);

   // Reset leaves no strobe pending and the queue open.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("result strobe or busy set right after reset");

   // Each result comes from S_ROUND, which returns to S_IDLE; strobes never touch.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // A saturated result sits at one of the two limits.
   a_ovf_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         (rsp_value == 24'h7FFFFF || rsp_value == 24'h800000))
      else $error("overflow flagged on a value that is not a limit");

endmodule

bind lagrange_interp_1d lip_checker u_lip_checker (
   .clock        (clock),
   .reset        (reset),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_value    (rsp_value),
   .rsp_overflow (rsp_overflow)
);
`default_nettype wire
